// ----- design/imu_oa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU offset averager package
// Shared types and constants for the digit-serial offset averager.
// ----------------------------------------------------------------------------
package imu_oa_pkg;

   localparam int AXES         = 6;
   localparam int READING_BITS = 16;
   localparam int DIGIT_BITS   = 8;

   localparam logic [READING_BITS-1:0] OFFSET_MAX = 16'h7FFF;
   localparam logic [READING_BITS-1:0] OFFSET_MIN = 16'h8000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_ABS,
      ST_DIV,
      ST_COMMIT,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic load;
      logic acc;
      logic abs_first;
      logic abs;
      logic div;
      logic commit;
   } lane_ctrl_type;

endpackage

// ----- design/imu_oa_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU offset averager axis lane
// Digit-serial running sum, magnitude pass, bit-serial restoring divider
// and stored offset for one axis.
// ----------------------------------------------------------------------------
module imu_oa_lane #(
   parameter int COUNT_BITS = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  imu_oa_pkg::lane_ctrl_type                    lane_ctrl,
   input  logic [imu_oa_pkg::READING_BITS-1:0]          reading,
   input  logic [COUNT_BITS:0]                          divisor,
   output logic [imu_oa_pkg::READING_BITS-1:0]          offset
);
   import imu_oa_pkg::*;

   localparam int SUM_BITS = READING_BITS + COUNT_BITS;
   localparam int DIGITS   = (SUM_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int PAD_BITS = DIGITS * DIGIT_BITS;

   logic [READING_BITS-1:0] reading_ff, reading_in;
   logic [PAD_BITS-1:0]     sum_ff, sum_in;
   logic                    carry_ff, carry_in;
   logic                    neg_ff, neg_in;
   logic [COUNT_BITS:0]     rem_ff, rem_in;
   logic [READING_BITS-1:0] offset_ff, offset_in;

   logic                    neg_now;
   logic [DIGIT_BITS-1:0]   op_a;
   logic [DIGIT_BITS-1:0]   op_b;
   logic                    cin;
   logic [DIGIT_BITS:0]     digit_sum;
   logic [COUNT_BITS+1:0]   shifted;
   logic [COUNT_BITS+1:0]   diff;
   logic                    hi_any;
   logic                    pos_over;
   logic                    neg_over;

   always_comb begin
      neg_now   = lane_ctrl.abs_first ? sum_ff[PAD_BITS-1] : neg_ff;
      op_a      = ((lane_ctrl.abs_first || lane_ctrl.abs) && neg_now) ?
                  ~sum_ff[DIGIT_BITS-1:0] : sum_ff[DIGIT_BITS-1:0];
      op_b      = lane_ctrl.acc ? reading_ff[DIGIT_BITS-1:0] : '0;
      cin       = lane_ctrl.abs_first ? sum_ff[PAD_BITS-1] : carry_ff;
      digit_sum = {1'b0, op_a} + {1'b0, op_b} + {{DIGIT_BITS{1'b0}}, cin};

      shifted   = {rem_ff, sum_ff[PAD_BITS-1]};
      diff      = shifted - {1'b0, divisor};

      hi_any    = |sum_ff[PAD_BITS-1:READING_BITS];
      pos_over  = hi_any || sum_ff[READING_BITS-1];
      neg_over  = hi_any || (sum_ff[READING_BITS-1] && (|sum_ff[READING_BITS-2:0]));

      reading_in = reading_ff;
      sum_in     = sum_ff;
      carry_in   = carry_ff;
      neg_in     = neg_ff;
      rem_in     = rem_ff;
      offset_in  = offset_ff;

      if (lane_ctrl.load) begin
         reading_in = reading;
         carry_in   = 1'b0;
      end else if (lane_ctrl.acc || lane_ctrl.abs_first || lane_ctrl.abs) begin
         reading_in = {{DIGIT_BITS{reading_ff[READING_BITS-1]}},
                       reading_ff[READING_BITS-1:DIGIT_BITS]};
         sum_in     = {digit_sum[DIGIT_BITS-1:0], sum_ff[PAD_BITS-1:DIGIT_BITS]};
         carry_in   = digit_sum[DIGIT_BITS];
         if (lane_ctrl.abs_first) begin
            neg_in = sum_ff[PAD_BITS-1];
            rem_in = '0;
         end
      end else if (lane_ctrl.div) begin
         if (!diff[COUNT_BITS+1]) begin
            rem_in = diff[COUNT_BITS:0];
            sum_in = {sum_ff[PAD_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[COUNT_BITS:0];
            sum_in = {sum_ff[PAD_BITS-2:0], 1'b0};
         end
      end else if (lane_ctrl.commit) begin
         if (neg_ff) begin
            offset_in = neg_over ? OFFSET_MIN :
                        READING_BITS'(~sum_ff[READING_BITS-1:0] + 16'd1);
         end else begin
            offset_in = pos_over ? OFFSET_MAX : sum_ff[READING_BITS-1:0];
         end
         sum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         offset_ff <= '0;
      end else begin
         sum_ff    <= sum_in;
         offset_ff <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      reading_ff <= reading_in;
      carry_ff   <= carry_in;
      neg_ff     <= neg_in;
      rem_ff     <= rem_in;
   end

   assign offset = offset_ff;

endmodule

// ----- design/imu_oa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU offset averager controller
// Sequences the digit passes, counts the sets of a window and runs the
// request and response handshakes.
// ----------------------------------------------------------------------------
module imu_oa_ctrl #(
   parameter int COUNT_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [COUNT_BITS-1:0]      sample_count,
   output imu_oa_pkg::lane_ctrl_type  lane_ctrl,
   output logic [COUNT_BITS:0]        divisor,
   output logic                       window_done,
   output logic                       rsp_load
);
   import imu_oa_pkg::*;

   localparam int SUM_BITS   = READING_BITS + COUNT_BITS;
   localparam int DIGITS     = (SUM_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int PAD_BITS   = DIGITS * DIGIT_BITS;
   localparam int STEP_BITS  = $clog2(PAD_BITS);

   state_type               state_ff, state_in;
   logic [STEP_BITS-1:0]    step_ff, step_in;
   logic [COUNT_BITS-1:0]   sets_ff, sets_in;
   logic [COUNT_BITS:0]     n_ff, n_in;
   logic                    done_ff, done_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    close;

   always_comb begin
      close        = ({1'b0, sample_count} <= n_ff);
      state_in     = state_ff;
      step_in      = step_ff;
      sets_in      = sets_ff;
      n_in         = n_ff;
      done_in      = done_ff;
      lane_ctrl    = '0;
      req_tready   = 1'b0;
      rsp_load     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               lane_ctrl.load = 1'b1;
               n_in           = {1'b0, sets_ff} + {{COUNT_BITS{1'b0}}, 1'b1};
               step_in        = '0;
               state_in       = ST_ACC;
            end
         end
         ST_ACC: begin
            lane_ctrl.acc = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(DIGITS - 1)) begin
               step_in = '0;
               done_in = close;
               if (close) begin
                  sets_in  = '0;
                  state_in = ST_ABS;
               end else begin
                  sets_in  = n_ff[COUNT_BITS-1:0];
                  state_in = ST_RESULT;
               end
            end
         end
         ST_ABS: begin
            lane_ctrl.abs_first = (step_ff == '0);
            lane_ctrl.abs       = (step_ff != '0);
            step_in             = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(DIGITS - 1)) begin
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            lane_ctrl.div = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(PAD_BITS - 1)) begin
               step_in  = '0;
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            lane_ctrl.commit = 1'b1;
            state_in         = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         sets_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         sets_ff      <= sets_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      done_ff <= done_in;
   end

   assign divisor     = n_ff;
   assign window_done = done_ff;
   assign rsp_tvalid  = rsp_valid_ff;

endmodule

// ----- design/imu_offset_averager.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU offset averager
// Block-average offset calibration over windows of six-axis reading sets.
// ----------------------------------------------------------------------------
// Each request carries one set of six signed readings and returns one response
// with the six stored offsets and a window-done flag. The sums are updated in
// eight-bit digits, D = ceil((16 + COUNT_BITS) / 8) of them per sum. A request
// that closes a window adds a magnitude pass over the digits, a bit-serial
// division of the padded sum and an offset commit. A new request is taken while
// the previous response still waits in the output register. A sample_count write
// of zero is held at one and a value above the counter range at its maximum.
module imu_offset_averager #(
   parameter int COUNT_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
   input  logic [95:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // offset_accel_x, offset_accel_y, offset_accel_z,
   // offset_gyro_x, offset_gyro_y, offset_gyro_z
   output logic [95:0]  rsp_tdata,
   // window_done
   output logic         rsp_tuser,
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata
);
   import imu_oa_pkg::*;

   localparam int VALUE_BITS = (COUNT_BITS > READING_BITS) ? COUNT_BITS : READING_BITS;
   localparam logic [VALUE_BITS-1:0] COUNT_MAX =
      {VALUE_BITS{1'b1}} >> (VALUE_BITS - COUNT_BITS);

   function automatic logic [COUNT_BITS-1:0] held_count(input logic [15:0] value);
      logic [VALUE_BITS-1:0] wide;
      wide = VALUE_BITS'(value);
      if (wide == '0) begin
         wide = VALUE_BITS'(1);
      end else if (wide > COUNT_MAX) begin
         wide = COUNT_MAX;
      end
      return wide[COUNT_BITS-1:0];
   endfunction

   logic [COUNT_BITS-1:0]                     sample_ff, sample_in;
   logic [AXES*READING_BITS-1:0]              rsp_data_ff, rsp_data_in;
   logic                                      rsp_user_ff, rsp_user_in;
   lane_ctrl_type                             lane_ctrl;
   logic [COUNT_BITS:0]                       divisor;
   logic                                      window_done;
   logic                                      rsp_load;
   logic [AXES-1:0][READING_BITS-1:0]         offsets;

   imu_oa_ctrl #(
      .COUNT_BITS (COUNT_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .sample_count (sample_ff),
      .lane_ctrl    (lane_ctrl),
      .divisor      (divisor),
      .window_done  (window_done),
      .rsp_load     (rsp_load)
   );

   for (genvar i = 0; i < AXES; i++) begin : g_lane
      imu_oa_lane #(
         .COUNT_BITS (COUNT_BITS)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .lane_ctrl (lane_ctrl),
         .reading   (req_tdata[i*READING_BITS +: READING_BITS]),
         .divisor   (divisor),
         .offset    (offsets[i])
      );
   end

   always_comb begin
      sample_in   = csr_we ? held_count(csr_wdata) : sample_ff;
      rsp_data_in = rsp_load ? offsets : rsp_data_ff;
      rsp_user_in = rsp_load ? window_done : rsp_user_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= held_count(16'd100);
      end else begin
         sample_ff <= sample_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   a_one_lane_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({lane_ctrl.load, lane_ctrl.acc, lane_ctrl.abs_first,
                lane_ctrl.abs, lane_ctrl.div, lane_ctrl.commit}))
      else $error("More than one lane operation is active.");

   a_accept_starts_sum: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> lane_ctrl.acc)
      else $error("An accepted request did not start the digit accumulation.");

   a_commit_blocks_req: assert property (@(posedge clock) disable iff (reset)
      lane_ctrl.commit |-> (!req_tready && !rsp_load))
      else $error("A request or response was handled during an offset commit.");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_tvalid || rsp_tready))
      else $error("The response register was overwritten before it was taken.");

endmodule
